// ----- src/gbpf_pkg.sv -----
`default_nettype none
package gbpf_pkg;

  localparam int SLOT_COUNT    = 14;
  localparam int V1_TEXT_BYTES = 16;
  localparam int V2_BIT        = 12;
  localparam int TEXT_BIT      = 15;
  localparam int FL_MOD        = 255;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_VALUE  = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [3:0] SLOT_END = 4'(SLOT_COUNT);
  localparam logic [7:0] V1_LIMIT = 8'(V1_TEXT_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_SRCH,
    S_VAL,
    S_TEXT,
    S_PAD,
    S_SUMA,
    S_SUMB
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       upd;
    logic [7:0] data;
  } fl_ctl_t;

  // Slot order is N M G X Y Z E F T S P I J R.
  function automatic logic slot_present(logic [3:0] k, logic [15:0] m, logic [2:0] e,
                                        logic v2);
    logic hit;
    hit = 1'b0;
    case (k)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: hit = m[k];
      4'd7:  hit = m[8];
      4'd8:  hit = m[9];
      4'd9:  hit = m[10];
      4'd10: hit = m[11];
      4'd11: hit = v2 & e[0];
      4'd12: hit = v2 & e[1];
      4'd13: hit = v2 & e[2];
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [2:0] slot_width(logic [3:0] k, logic v2);
    logic [2:0] w;
    case (k)
      4'd0:       w = 3'd2;
      4'd1, 4'd2: w = v2 ? 3'd2 : 3'd1;
      4'd8:       w = 3'd1;
      default:    w = 3'd4;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- src/gbpf_if.sv -----
`default_nettype none
interface gbpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] presence_mask;
  logic [2:0]  extended_mask;
  logic [7:0]  text_length;
  logic [31:0] value_word;

  modport source (output valid, output operation, output presence_mask,
                  output extended_mask, output text_length, output value_word,
                  input ready);
  modport sink (input valid, input operation, input presence_mask,
                input extended_mask, input text_length, input value_word,
                output ready);
endinterface

interface gbpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- src/gbpf_fletcher.sv -----
`default_nettype none
module gbpf_fletcher (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gbpf_pkg::fl_ctl_t ctl,
  output logic [7:0]            sum_a,
  output logic [7:0]            sum_b
);
  import gbpf_pkg::*;

  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [8:0] add_a, add_b;
  logic [8:0] red_a, red_b;

  // Both operands stay below 510, so one conditional subtract reduces mod 255.
  always_comb begin
    add_a     = {1'b0, sum_a_r} + {1'b0, ctl.data};
    red_a     = (add_a >= 9'(FL_MOD)) ? add_a - 9'(FL_MOD) : add_a;
    add_b     = {1'b0, sum_b_r} + red_a;
    red_b     = (add_b >= 9'(FL_MOD)) ? add_b - 9'(FL_MOD) : add_b;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (ctl.clr) begin
      sum_a_nxt = '0;
      sum_b_nxt = '0;
    end else if (ctl.upd) begin
      sum_a_nxt = red_a[7:0];
      sum_b_nxt = red_b[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
    end else begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  assign sum_a = sum_a_r;
  assign sum_b = sum_b_r;

`ifndef SYNTHESIS
  a_sum_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_a_r < 8'(FL_MOD)) else $error("sum A out of range");
  a_sum_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_b_r < 8'(FL_MOD)) else $error("sum B out of range");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (sum_a_r == 8'd0) && (sum_b_r == 8'd0)) else $error("sums not cleared");
`endif

endmodule
`default_nettype wire

// ----- src/gbpf_ostage.sv -----
`default_nettype none
module gbpf_ostage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] push_byte,
  input  wire logic       push_last,
  output logic            can_push,
  gbpf_out_if.source      out_ch
);
  import gbpf_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  assign can_push = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      byte_r <= push_byte;
      last_r <= push_last;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.last_byte = last_r;

endmodule
`default_nettype wire

// ----- src/gcode_binary_packet_framer_core.sv -----
//  Channel | Direction | Words                 | Payload
//  in_ch   | sink      | one command item      | operation, masks, text_length, value_word
//  out_ch  | source    | one packet byte       | out_byte, last_byte
//
//  An item is taken only in the idle state, so a new item waits until the last one is done.
//  Begin sends the header bytes, a value searches for its slot and sends its bytes,
//  a text byte sends at most one byte, and a finish sends the zero padding and both sums.
//  The single output register holds each byte; the search checks one slot per cycle.
//  Reset is synchronous and clears the masks, counters and both checksum sums.
//  A stalled output holds the sequencer in any state with a byte to send; nothing is dropped.
`default_nettype none
module gcode_binary_packet_framer_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbpf_in_if.sink    in_ch,
  gbpf_out_if.source out_ch
);
  import gbpf_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [2:0]  ext_r, ext_nxt;
  logic [3:0]  next_param_r, next_param_nxt;
  logic [7:0]  text_cnt_r, text_cnt_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [31:0] word_r, word_nxt;

  logic        acc, v2, has_text;
  logic        hdr_done, slot_hit, search_end, val_last, text_go, pad_go;
  logic [2:0]  width;
  logic        can_push, push, push_last;
  logic [7:0]  push_byte;
  logic [7:0]  sum_a, sum_b;
  fl_ctl_t     fl_ctl;

  assign acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign v2       = mask_r[V2_BIT];
  assign has_text = mask_r[TEXT_BIT];

  assign hdr_done   = ((hdr_idx_r == 3'd1) && !v2) ||
                      ((hdr_idx_r == 3'd3) && v2 && !has_text) ||
                      (hdr_idx_r == 3'd4);
  assign search_end = (next_param_r >= SLOT_END);
  assign slot_hit   = slot_present(next_param_r, mask_r, ext_r, v2);
  assign width      = slot_width(next_param_r, v2);
  assign val_last   = ({1'b0, bidx_r} == (width - 3'd1));
  assign text_go    = has_text && ((v2 && (text_cnt_r != 8'd0)) ||
                                   (!v2 && (text_cnt_r < V1_LIMIT)));
  assign pad_go     = has_text && !v2 && (text_cnt_r < V1_LIMIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_ch.operation)
            OP_BEGIN:  state_nxt = S_HDR;
            OP_VALUE:  state_nxt = S_SRCH;
            OP_TEXT:   state_nxt = S_TEXT;
            OP_FINISH: state_nxt = S_PAD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        if (can_push && hdr_done) state_nxt = S_IDLE;
      end
      S_SRCH: begin
        if (search_end) begin
          state_nxt = S_IDLE;
        end else if (slot_hit) begin
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        if (can_push && val_last) state_nxt = S_IDLE;
      end
      S_TEXT: begin
        if (!text_go || can_push) state_nxt = S_IDLE;
      end
      S_PAD: begin
        if (!pad_go) state_nxt = S_SUMA;
      end
      S_SUMA: begin
        if (can_push) state_nxt = S_SUMB;
      end
      S_SUMB: begin
        if (can_push) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mask_nxt       = mask_r;
    ext_nxt        = ext_r;
    next_param_nxt = next_param_r;
    text_cnt_nxt   = text_cnt_r;
    hdr_idx_nxt    = hdr_idx_r;
    bidx_nxt       = bidx_r;
    word_nxt       = word_r;
    push           = 1'b0;
    push_byte      = '0;
    push_last      = 1'b0;
    fl_ctl.clr     = 1'b0;
    fl_ctl.upd     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          word_nxt = in_ch.value_word;
          bidx_nxt = '0;
          if (in_ch.operation == OP_BEGIN) begin
            mask_nxt       = in_ch.presence_mask;
            ext_nxt        = in_ch.extended_mask;
            next_param_nxt = '0;
            hdr_idx_nxt    = '0;
            fl_ctl.clr     = 1'b1;
            text_cnt_nxt   = (in_ch.presence_mask[V2_BIT] && in_ch.presence_mask[TEXT_BIT]) ?
                             in_ch.text_length : 8'd0;
          end
        end
      end
      S_HDR: begin
        case (hdr_idx_r)
          3'd0:    push_byte = mask_r[7:0];
          3'd1:    push_byte = mask_r[15:8];
          3'd2:    push_byte = {5'd0, ext_r};
          3'd4:    push_byte = text_cnt_r;
          default: push_byte = 8'd0;
        endcase
        if (can_push) begin
          push        = 1'b1;
          fl_ctl.upd  = 1'b1;
          hdr_idx_nxt = hdr_idx_r + 3'd1;
        end
      end
      S_SRCH: begin
        if (!search_end && !slot_hit) next_param_nxt = next_param_r + 4'd1;
      end
      S_VAL: begin
        push_byte = word_r[{bidx_r, 3'b000} +: 8];
        if (can_push) begin
          push       = 1'b1;
          fl_ctl.upd = 1'b1;
          bidx_nxt   = bidx_r + 2'd1;
          if (val_last) next_param_nxt = next_param_r + 4'd1;
        end
      end
      S_TEXT: begin
        push_byte = word_r[7:0];
        if (has_text) next_param_nxt = SLOT_END;
        if (text_go && can_push) begin
          push         = 1'b1;
          fl_ctl.upd   = 1'b1;
          text_cnt_nxt = v2 ? text_cnt_r - 8'd1 : text_cnt_r + 8'd1;
        end
      end
      S_PAD: begin
        push_byte = 8'd0;
        if (pad_go && can_push) begin
          push         = 1'b1;
          fl_ctl.upd   = 1'b1;
          text_cnt_nxt = text_cnt_r + 8'd1;
        end
      end
      S_SUMA: begin
        push_byte = sum_a;
        push      = can_push;
      end
      S_SUMB: begin
        push_byte = sum_b;
        push_last = 1'b1;
        if (can_push) begin
          push           = 1'b1;
          fl_ctl.clr     = 1'b1;
          mask_nxt       = '0;
          ext_nxt        = '0;
          next_param_nxt = '0;
          text_cnt_nxt   = '0;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    fl_ctl.data = push_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mask_r       <= '0;
      ext_r        <= '0;
      next_param_r <= '0;
      text_cnt_r   <= '0;
      hdr_idx_r    <= '0;
      bidx_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      mask_r       <= mask_nxt;
      ext_r        <= ext_nxt;
      next_param_r <= next_param_nxt;
      text_cnt_r   <= text_cnt_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      bidx_r       <= bidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  gbpf_fletcher u_fletcher (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fl_ctl),
    .sum_a (sum_a),
    .sum_b (sum_b)
  );

  gbpf_ostage u_ostage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_byte (push_byte),
    .push_last (push_last),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_param_r <= SLOT_END) else $error("slot index past end");
  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> (state_r == S_IDLE) && (mask_r == 16'd0) &&
                            (next_param_r == 4'd0)) else $error("packet state not cleared");
  a_v1_text_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !mask_r[V2_BIT] |-> (text_cnt_r <= V1_LIMIT)) else $error("text count over limit");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/gcode_binary_packet_framer_core_test.sv -----
`default_nettype none
module gcode_binary_packet_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbpf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_byte_t;

  localparam int MASK_BIT [0:10] = '{0, 1, 2, 3, 4, 5, 6, 8, 9, 10, 11};

  logic clk;
  logic rst_n;

  gbpf_in_if  cmd_if ();
  gbpf_out_if pkt_if ();

  gcode_binary_packet_framer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (pkt_if)
  );

  packet_byte_t packet_bytes_due[$];

  logic [15:0] cmd_mask;
  logic [2:0]  arc_mask;
  int          slot_ptr;
  int          text_count;
  int          fletcher_a;
  int          fletcher_b;

  int mismatches;
  int bytes_checked;
  int words_sent;
  int busy_words;
  int packets_closed;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("gcode_binary_packet_framer_core verification failed");
    $finish;
  end

  function automatic logic param_present(int k, logic [15:0] pm, logic [2:0] em);
    if (k < 11) begin
      return pm[MASK_BIT[k]];
    end
    if (k < SLOT_COUNT) begin
      return pm[V2_BIT] && em[k - 11];
    end
    return 1'b0;
  endfunction

  function automatic int param_bytes(int k, logic v2);
    if (k == 0) begin
      return 2;
    end
    if (k == 1 || k == 2) begin
      return v2 ? 2 : 1;
    end
    if (k == 8) begin
      return 1;
    end
    return 4;
  endfunction

  function automatic int count_params(logic [15:0] pm, logic [2:0] em);
    int n;
    n = 0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (param_present(k, pm, em)) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic void clear_framer();
    cmd_mask   = '0;
    arc_mask   = '0;
    slot_ptr   = 0;
    text_count = 0;
    fletcher_a = 0;
    fletcher_b = 0;
  endfunction

  function automatic void add_summed(logic [7:0] b);
    fletcher_a = (fletcher_a + b) % FL_MOD;
    fletcher_b = (fletcher_b + fletcher_a) % FL_MOD;
    packet_bytes_due.push_back('{data: b, last: 1'b0});
  endfunction

  // Returns the number of packet bytes that the command word adds.
  function automatic int frame_command(logic [1:0] op, logic [15:0] pm, logic [2:0] em,
                                       logic [7:0] tl, logic [31:0] vw);
    int   k;
    int   start;
    logic v2;
    logic has_text;
    start    = packet_bytes_due.size();
    v2       = cmd_mask[V2_BIT];
    has_text = cmd_mask[TEXT_BIT];
    case (op)
      OP_BEGIN: begin
        clear_framer();
        cmd_mask = pm;
        arc_mask = em;
        add_summed(pm[7:0]);
        add_summed(pm[15:8]);
        if (pm[V2_BIT]) begin
          add_summed({5'b0, em});
          add_summed(8'h00);
          if (pm[TEXT_BIT]) begin
            text_count = tl;
            add_summed(tl);
          end
        end
      end
      OP_VALUE: begin
        k = slot_ptr;
        while (k < SLOT_COUNT && !param_present(k, cmd_mask, arc_mask)) begin
          k++;
        end
        if (k < SLOT_COUNT) begin
          for (int i = 0; i < param_bytes(k, v2); i++) begin
            add_summed(vw[8*i +: 8]);
          end
          slot_ptr = k + 1;
        end else begin
          slot_ptr = SLOT_COUNT;
        end
      end
      OP_TEXT: begin
        if (has_text) begin
          slot_ptr = SLOT_COUNT;
          if (v2) begin
            if (text_count > 0) begin
              add_summed(vw[7:0]);
              text_count--;
            end
          end else if (text_count < V1_TEXT_BYTES) begin
            add_summed(vw[7:0]);
            text_count++;
          end
        end
      end
      default: begin
        if (has_text && !v2) begin
          while (text_count < V1_TEXT_BYTES) begin
            add_summed(8'h00);
            text_count++;
          end
        end
        packet_bytes_due.push_back('{data: 8'(fletcher_a), last: 1'b0});
        packet_bytes_due.push_back('{data: 8'(fletcher_b), last: 1'b1});
        clear_framer();
        packets_closed++;
      end
    endcase
    return packet_bytes_due.size() - start;
  endfunction

  task automatic put_command(input logic [1:0] op, input logic [15:0] pm,
                             input logic [2:0] em, input logic [7:0] tl,
                             input logic [31:0] vw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (frame_command(op, pm, em, tl, vw) > 0) begin
      busy_words++;
    end
    words_sent++;
    cmd_if.valid         <= 1'b1;
    cmd_if.operation     <= op;
    cmd_if.presence_mask <= pm;
    cmd_if.extended_mask <= em;
    cmd_if.text_length   <= tl;
    cmd_if.value_word    <= vw;
    do begin
      @(posedge clk);
    end while (!cmd_if.ready);
    burst_left--;
  endtask

  task automatic send_begin(input logic [15:0] pm, input logic [2:0] em,
                            input logic [7:0] tl);
    put_command(OP_BEGIN, pm, em, tl, $urandom);
  endtask

  task automatic send_value(input logic [31:0] vw);
    put_command(OP_VALUE, 16'($urandom), 3'($urandom), 8'($urandom), vw);
  endtask

  task automatic send_text(input logic [31:0] vw);
    put_command(OP_TEXT, 16'($urandom), 3'($urandom), 8'($urandom), vw);
  endtask

  task automatic send_finish();
    put_command(OP_FINISH, 16'($urandom), 3'($urandom), 8'($urandom), $urandom);
  endtask

  initial begin : packet_sink
    int mode;
    int left;
    packet_byte_t due;
    mode = 0;
    left = 0;
    pkt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pkt_if.valid && pkt_if.ready) begin
        bytes_checked++;
        if (packet_bytes_due.size() == 0) begin
          $error("unexpected packet byte %02h (last %0b)", pkt_if.out_byte,
                 pkt_if.last_byte);
          mismatches++;
        end else begin
          due = packet_bytes_due.pop_front();
          if (pkt_if.out_byte !== due.data) begin
            $error("out_byte: expected %02h, got %02h", due.data, pkt_if.out_byte);
            mismatches++;
          end
          if (pkt_if.last_byte !== due.last) begin
            $error("last_byte: expected %0b, got %0b", due.last, pkt_if.last_byte);
            mismatches++;
          end
        end
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 80);
      end
      left--;
      case (mode)
        0: pkt_if.ready <= 1'b1;
        1: pkt_if.ready <= ($urandom_range(0, 3) != 0);
        2: pkt_if.ready <= ($urandom_range(0, 3) == 0);
        default: pkt_if.ready <= (left % 5 == 0);
      endcase
    end
  end

  task automatic test_finish_without_begin();
    send_finish();
  endtask

  // Version one with text: width-one M, G and T, text cut short, zero padding.
  task automatic test_v1_packet();
    send_begin(16'h8307, 3'd7, 8'd255);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'h0000_00A5);
    send_value(32'h3F80_0000);
    send_value(32'hFFFF_FF01);
    send_text(32'h0000_0047);
    send_text(32'hFFFF_FF31);
    send_value(32'h1234_5678);
    send_finish();
  endtask

  // Version two with the arc words, a value with no slot left and text past its length.
  task automatic test_v2_packet();
    send_begin(16'h9003, 3'b101, 8'd1);
    send_value(32'hFFFF_8001);
    send_value(32'h0000_7FFE);
    send_value(32'hC2C8_0000);
    send_value(32'h4120_0000);
    send_value(32'hDEAD_BEEF);
    send_text(32'h0000_0041);
    send_text(32'h0000_0042);
    send_finish();
  endtask

  task automatic test_restart_and_stray_words();
    send_begin(16'h0018, 3'd0, 8'd0);
    send_value(32'h0102_0304);
    send_begin(16'h9000, 3'd0, 8'd0);
    send_text(32'h0000_00FF);
    send_finish();
    send_begin(16'h0078, 3'd2, 8'd0);
    send_value(32'h8000_0000);
    send_text(32'h0000_0055);
    send_finish();
  endtask

  task automatic test_random_packets();
    logic [15:0] pm;
    logic [2:0]  em;
    logic [7:0]  tl;
    int          goal;
    int          n_values;
    int          n_text;
    goal = words_sent + 215;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          put_command(2'($urandom), 16'($urandom), 3'($urandom), 8'($urandom), $urandom);
        end
      end else begin
        pm = 16'($urandom);
        em = 3'($urandom);
        tl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, 6));
        send_begin(pm, em, tl);
        n_values = count_params(pm, em);
        if ($urandom_range(0, 3) == 0) begin
          n_values = n_values + $urandom_range(0, 2) - 1;
        end
        repeat (n_values) begin
          send_value($urandom);
        end
        if (!pm[TEXT_BIT]) begin
          n_text = $urandom_range(0, 1);
        end else if (pm[V2_BIT]) begin
          n_text = ((tl > 20) ? 20 : int'(tl)) + $urandom_range(0, 2);
        end else begin
          n_text = $urandom_range(0, 20);
        end
        repeat (n_text) begin
          send_text($urandom);
        end
        if ($urandom_range(0, 9) != 0) begin
          send_finish();
        end
      end
    end
  endtask

  initial begin
    mismatches     = 0;
    bytes_checked  = 0;
    words_sent     = 0;
    busy_words     = 0;
    packets_closed = 0;
    burst_left     = 0;
    clear_framer();
    rst_n                <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.operation     <= OP_BEGIN;
    cmd_if.presence_mask <= '0;
    cmd_if.extended_mask <= '0;
    cmd_if.text_length   <= '0;
    cmd_if.value_word    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_finish_without_begin();
    test_v1_packet();
    test_v2_packet();
    test_restart_and_stray_words();
    test_random_packets();

    cmd_if.valid <= 1'b0;
    while (packet_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    $display("Sent %0d command words (%0d of them producing bytes), closed %0d packets.",
             words_sent, busy_words, packets_closed);
    $display("Compared %0d packet bytes against the framing and checksum predictor.",
             bytes_checked);
    if (mismatches == 0) begin
      $display("gcode_binary_packet_framer_core verification clean");
    end else begin
      $display("gcode_binary_packet_framer_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
